>>> rtl/core/sct_pkg.sv
`timescale 1ns / 1ps
// Package for the source character tokenizer: beat types, token kinds, scan modes,
// character constants and the classification and saturation functions.
// Depends on nothing; every module of the block imports it.
package sct_pkg;

	localparam int OFFSET_WIDTH = 20;
	localparam int COUNT_WIDTH  = 16;
	localparam int MAX_RESULTS  = 3;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
	localparam int SLOT_WIDTH   = $clog2(MAX_RESULTS + 1);
	localparam int OSUM_WIDTH   = ((OFFSET_WIDTH > COUNT_WIDTH) ? OFFSET_WIDTH : COUNT_WIDTH) + 1;

	localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0]  CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0]  CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0]  CNT_TWO = COUNT_WIDTH'(2);

	localparam logic [2:0] KIND_IDENT = 3'd0;
	localparam logic [2:0] KIND_INT   = 3'd1;
	localparam logic [2:0] KIND_FLOAT = 3'd2;
	localparam logic [2:0] KIND_OP    = 3'd3;
	localparam logic [2:0] KIND_EOF   = 3'd4;
	localparam logic [2:0] KIND_ERR   = 3'd5;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_INTDOT,
		MODE_FLOAT
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_marker;
	} char_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic [7:0]              char_value;
		logic [OFFSET_WIDTH-1:0] start_offset;
		logic [COUNT_WIDTH-1:0]  token_length;
		logic [COUNT_WIDTH-1:0]  start_line;
		logic [COUNT_WIDTH-1:0]  start_column;
		logic                    last;
	} tok_t;

	typedef struct packed {
		logic [SLOT_WIDTH-1:0]    count;
		tok_t [MAX_RESULTS-1:0]   tok;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} push_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_EQ || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_add_cnt(input logic [COUNT_WIDTH-1:0] a,
			input logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? CNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [OFFSET_WIDTH-1:0] sat_add_off(input logic [OFFSET_WIDTH-1:0] a,
			input logic [COUNT_WIDTH-1:0] b);
		logic [OSUM_WIDTH-1:0] s;
		s = OSUM_WIDTH'(a) + OSUM_WIDTH'(b);
		return (s > OSUM_WIDTH'(OFF_MAX)) ? OFF_MAX : OFFSET_WIDTH'(s);
	endfunction

endpackage

>>> rtl/core/sct_front.sv
`timescale 1ns / 1ps
// Front end of the tokenizer: accepts character beats, classifies them, keeps the
// scan state and counters, and pushes the tokens each beat causes as one bundle.
// Depends on sct_pkg.
module sct_front import sct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  char_valid,
	output logic  char_ready,
	input  char_t char_beat,
	input  logic  q_full,
	output push_t push
);

	scan_mode_t              mode_q, mode_n;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_n, tso_q, tso_n;
	logic [COUNT_WIDTH-1:0]  line_q, line_n, col_q, col_n, tsc_q, tsc_n, run_q, run_n;

	logic [7:0]            c;
	logic                  eos, lt, dg, sp, dot, cont, acc, has_cur;
	logic [SLOT_WIDTH-1:0] nf, total;
	tok_t                  ft0, ft1, cur;

	assign c   = char_beat.char_code;
	assign eos = char_beat.end_marker;
	assign lt  = is_letter(c);
	assign dg  = is_digit(c);
	assign sp  = is_space(c);
	assign dot = c == CH_DOT;
	assign char_ready = !q_full;
	assign acc = char_valid && char_ready;

	assign cont = !eos && (((mode_q == MODE_IDENT) && (lt || dg)) ||
		((mode_q == MODE_INT) && (dg || dot)) ||
		(((mode_q == MODE_INTDOT) || (mode_q == MODE_FLOAT)) && dg));

	always_comb begin
		mode_n = mode_q;
		pos_n  = pos_q;
		line_n = line_q;
		col_n  = col_q;
		tso_n  = tso_q;
		tsc_n  = tsc_q;
		run_n  = run_q;
		if (eos) begin
			mode_n = MODE_IDLE;
			pos_n  = '0;
			line_n = CNT_ONE;
			col_n  = CNT_ONE;
			tso_n  = '0;
			tsc_n  = CNT_ONE;
			run_n  = '0;
		end else begin
			pos_n = sat_add_off(pos_q, CNT_ONE);
			if (c == CH_NL) begin
				line_n = sat_add_cnt(line_q, CNT_ONE);
				col_n  = CNT_ONE;
			end else begin
				col_n = sat_add_cnt(col_q, CNT_ONE);
			end
			if (cont) begin
				case (mode_q)
					MODE_INT: begin
						if (dg) begin
							run_n = sat_add_cnt(run_q, CNT_ONE);
						end else begin
							mode_n = MODE_INTDOT;
						end
					end
					MODE_INTDOT: begin
						mode_n = MODE_FLOAT;
						run_n  = sat_add_cnt(run_q, CNT_TWO);
					end
					default: begin
						run_n = sat_add_cnt(run_q, CNT_ONE);
					end
				endcase
			end else begin
				mode_n = MODE_IDLE;
				if (lt || dg) begin
					mode_n = lt ? MODE_IDENT : MODE_INT;
					tso_n  = pos_q;
					tsc_n  = col_q;
					run_n  = CNT_ONE;
				end
			end
		end
	end

	always_comb begin
		ft0 = '{kind: KIND_IDENT, char_value: CH_NUL, start_offset: tso_q,
			token_length: run_q, start_line: line_q, start_column: tsc_q, last: 1'b0};
		ft1 = '{kind: KIND_ERR, char_value: CH_DOT,
			start_offset: sat_add_off(tso_q, run_q), token_length: CNT_ONE,
			start_line: line_q, start_column: sat_add_cnt(tsc_q, run_q), last: 1'b0};
		nf = '0;
		case (mode_q)
			MODE_IDENT: begin
				nf = SLOT_WIDTH'(1);
			end
			MODE_INT: begin
				ft0.kind = KIND_INT;
				nf = SLOT_WIDTH'(1);
			end
			MODE_FLOAT: begin
				ft0.kind = KIND_FLOAT;
				nf = SLOT_WIDTH'(1);
			end
			MODE_INTDOT: begin
				ft0.kind = KIND_INT;
				nf = SLOT_WIDTH'(2);
			end
			default: begin
				nf = '0;
			end
		endcase
		if (cont) begin
			nf = '0;
		end

		cur = '{kind: KIND_EOF, char_value: CH_NUL, start_offset: pos_q,
			token_length: '0, start_line: line_q, start_column: col_q, last: 1'b0};
		has_cur = eos;
		if (!eos && !cont && !sp && !lt && !dg) begin
			has_cur = 1'b1;
			cur.kind = is_op(c) ? KIND_OP : KIND_ERR;
			cur.char_value = c;
			cur.token_length = CNT_ONE;
		end
		total = nf + SLOT_WIDTH'(has_cur);

		push.valid = acc && (total != '0);
		push.bundle.count = total;
		push.bundle.tok[0] = (nf != '0) ? ft0 : cur;
		push.bundle.tok[1] = (nf == SLOT_WIDTH'(2)) ? ft1 : cur;
		push.bundle.tok[2] = cur;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			push.bundle.tok[i].last = (SLOT_WIDTH'(i) == (total - SLOT_WIDTH'(1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			line_q <= CNT_ONE;
			col_q  <= CNT_ONE;
			tso_q  <= '0;
			tsc_q  <= CNT_ONE;
			run_q  <= '0;
		end else if (acc) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			line_q <= line_n;
			col_q  <= col_n;
			tso_q  <= tso_n;
			tsc_q  <= tsc_n;
			run_q  <= run_n;
		end
	end

endmodule

>>> rtl/core/sct_queue.sv
`timescale 1ns / 1ps
// Short bundle queue between the tokenizer front end and back end.
// Depends on sct_pkg.
module sct_queue import sct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	bundle_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_WIDTH:0]     fill_q;
	logic                    do_pop;

	assign full   = fill_q == (QPTR_WIDTH + 1)'(QUEUE_DEPTH);
	assign empty  = fill_q == '0;
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_WIDTH'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_WIDTH'(1);
			end
			if (push.valid && !do_pop) begin
				fill_q <= fill_q + (QPTR_WIDTH + 1)'(1);
			end else if (!push.valid && do_pop) begin
				fill_q <= fill_q - (QPTR_WIDTH + 1)'(1);
			end
		end
	end

endmodule

>>> rtl/core/sct_back.sv
`timescale 1ns / 1ps
// Back end of the tokenizer: walks the tokens of the head bundle and presents
// them one beat at a time from an output register.
// Depends on sct_pkg.
module sct_back import sct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  bundle_t head,
	output logic    pop,
	output logic    tok_valid,
	input  logic    tok_ready,
	output tok_t    tok_beat
);

	logic [SLOT_WIDTH-1:0] idx_q;
	logic                  valid_q, load, tail;
	tok_t                  out_q;

	assign load = !empty && (!valid_q || tok_ready);
	assign tail = idx_q == (head.count - SLOT_WIDTH'(1));
	assign pop  = load && tail;
	assign tok_valid = valid_q;
	assign tok_beat  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.tok[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= tail ? '0 : idx_q + SLOT_WIDTH'(1);
			end else if (tok_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/source_char_tokenizer.sv
`timescale 1ns / 1ps
// Source character tokenizer: one character beat in, zero to three token beats out.
// The first token of a character passes through the queue memory and the output register.
// Throughput: one character per cycle unless the queue is full; the output register sends
// one token per cycle while tok_ready is high and pops a bundle when its last token loads.
// Reset clears the scan state to offset 0, line 1, column 1 and empties the queue.
// Depends on sct_pkg, sct_front, sct_queue and sct_back.
module source_char_tokenizer import sct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  char_valid,
	output logic  char_ready,
	input  char_t char_beat,
	output logic  tok_valid,
	input  logic  tok_ready,
	output tok_t  tok_beat
);

	push_t   push;
	bundle_t head;
	logic    q_full, q_empty, pop;

	sct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_beat  (char_beat),
		.q_full     (q_full),
		.push       (push)
	);

	sct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.head   (head)
	);

	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_beat  (tok_beat)
	);

endmodule
